/* rtl/core/acm_pkg.sv */
`default_nettype none

package acm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [1:0] CFG_ODD_SYM     = 2'd1;
    localparam logic [1:0] CFG_DIR_POS     = 2'd2;
    localparam logic [1:0] CFG_GAIN        = 2'd3;

    // Region codes as reported on the result
    typedef enum logic [1:0] {
        REGION_POLY = 2'd0,
        REGION_LOW  = 2'd1,
        REGION_HIGH = 2'd2,
        REGION_NONE = 2'd3
    } t_region;

    // Table read address select
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_ONE,
        RD_NM2,
        RD_NM1,
        RD_IDX
    } t_rd;

    // Table read data capture select
    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_P0,
        CAP_P1,
        CAP_PA,
        CAP_PB,
        CAP_COEF
    } t_cap;

    // Shared multiplier operand select
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_SQ,
        MUL_GLO,
        MUL_GHI,
        MUL_HLO,
        MUL_HHI,
        MUL_SEG,
        MUL_FLO,
        MUL_FHI
    } t_mul;

    // Wide accumulator operation
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD24,
        ACC_ADD32,
        ACC_SQ
    } t_acc;

    // One-shot datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_LATCH,
        OP_DECIDE,
        OP_HSTEP,
        OP_PEND,
        OP_FLAT,
        OP_DIVINIT,
        OP_DIV,
        OP_SEND,
        OP_CSAT,
        OP_FEND
    } t_op;

    typedef struct packed {
        t_op  op;
        t_rd  rd;
        t_cap cap;
        t_mul mul;
        t_acc acc;
    } t_cmd;

    typedef struct packed {
        t_region region;
        logic    den_le0;
        logic    div_last;
        logic    idx_zero;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/core/acm_ram.sv */
`default_nettype none

module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/acm_dp.sv */
`default_nettype none

module acm_dp #(
    parameter int MAX_POINTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic [3:0]         i_entry_index,
    input  wire logic signed [24:0] i_point_angle,
    input  wire logic signed [31:0] i_point_value,
    input  wire logic signed [47:0] i_poly_coef,
    input  wire logic signed [24:0] i_slip_angle,
    input  wire logic [23:0]        i_speed,
    input  wire acm_pkg::t_cmd      i_cmd,
    output acm_pkg::t_stat          o_stat,
    output logic signed [31:0]      o_coefficient,
    output logic signed [47:0]      o_force_res,
    output logic [1:0]              o_region
);

    localparam int AW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NWR = $clog2(MAX_POINTS + 1);
    localparam int NW  = (NWR > 5) ? NWR : 5;

    // Configuration registers
    logic [4:0]  r_point_count;
    logic        r_odd;
    logic        r_dir;
    logic [23:0] r_gain;

    // Item and table capture registers
    logic signed [24:0] r_slip;
    logic [24:0]        r_a;
    logic [23:0]        r_spd;
    logic signed [24:0] r_x0, r_x1, r_xa, r_xb;
    logic signed [31:0] r_y0, r_y1, r_ya, r_yb;
    logic signed [47:0] r_hacc, r_hcoef;
    logic [AW-1:0]      r_idx;

    // Arithmetic registers
    logic [66:0]        r_mul;
    logic [81:0]        r_wide;
    logic [47:0]        r_sq;
    logic [39:0]        r_g;
    logic               r_seg_hi;
    acm_pkg::t_region   r_region;
    logic [25:0]        r_rem;
    logic [33:0]        r_quo;
    logic               r_dovf;
    logic [4:0]         r_dcnt;
    logic signed [41:0] r_cpre;
    logic signed [31:0] r_c;

    // Result registers
    logic signed [31:0] r_coef_o;
    logic signed [47:0] r_force_o;
    logic [1:0]         r_region_o;

    logic [NW-1:0] pc_w, n_pts;
    logic [AW-1:0] idx_nm1, idx_nm2, rd_addr, wr_addr;
    logic          wr_en;
    logic [24:0]   ang_q;
    logic [31:0]   val_q;
    logic [47:0]   coef_q;

    logic signed [25:0] ae, x0e, x1e, xae;
    acm_pkg::t_region   region_w;

    logic signed [24:0] sx0, sx1;
    logic signed [31:0] sy0, sy1;
    logic signed [25:0] den, dx;
    logic signed [32:0] dy;
    logic [32:0]        dymag;

    logic [47:0] hmag;
    logic [31:0] cmag;
    logic [33:0] u;
    logic [32:0] mul_a;
    logic [33:0] mul_b;

    logic [81:0]        hrnd, frnd;
    logic [49:0]        ht;
    logic [48:0]        hcap;
    logic signed [50:0] hsgn;
    logic signed [51:0] hsum;
    logic [39:0]        pm;
    logic [58:0]        dvd;
    logic [25:0]        d_rem;
    logic [33:0]        d_quo;
    logic [34:0]        q35;
    logic signed [41:0] cmir;
    logic [57:0]        ft;
    logic [48:0]        fcap;
    logic signed [49:0] fs, fd;

    function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
        if (&v[51:47] || ~|v[51:47]) begin
            return v[47:0];
        end
        return v[51] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (&v[41:31] || ~|v[41:31]) begin
            return v[31:0];
        end
        return v[41] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    endfunction

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= 5'd16;
            r_odd         <= 1'b0;
            r_dir         <= 1'b1;
            r_gain        <= 24'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                acm_pkg::CFG_POINT_COUNT: r_point_count <= i_cfg_data[4:0];
                acm_pkg::CFG_ODD_SYM:     r_odd         <= i_cfg_data[0];
                acm_pkg::CFG_DIR_POS:     r_dir         <= i_cfg_data[0];
                acm_pkg::CFG_GAIN:        r_gain        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the point count to the table
    assign pc_w = NW'(r_point_count);
    always_comb begin
        if (pc_w < NW'(4)) begin
            n_pts = NW'(4);
        end else if (pc_w > NW'(MAX_POINTS)) begin
            n_pts = NW'(MAX_POINTS);
        end else begin
            n_pts = pc_w;
        end
    end
    assign idx_nm1 = AW'(n_pts - NW'(1));
    assign idx_nm2 = AW'(n_pts - NW'(2));

    // Table memories
    assign wr_en   = (i_cmd.op == acm_pkg::OP_LOAD) && (32'(i_entry_index) < 32'(MAX_POINTS));
    assign wr_addr = AW'(i_entry_index);

    always_comb begin
        case (i_cmd.rd)
            acm_pkg::RD_ZERO: rd_addr = '0;
            acm_pkg::RD_ONE:  rd_addr = AW'(1);
            acm_pkg::RD_NM2:  rd_addr = idx_nm2;
            acm_pkg::RD_NM1:  rd_addr = idx_nm1;
            acm_pkg::RD_IDX:  rd_addr = r_idx;
            default:          rd_addr = '0;
        endcase
    end

    acm_ram #(.WIDTH(25), .DEPTH(MAX_POINTS)) u_ang (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_point_angle),
        .i_raddr (rd_addr),
        .o_rdata (ang_q)
    );

    acm_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_val (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_point_value),
        .i_raddr (rd_addr),
        .o_rdata (val_q)
    );

    acm_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_coef (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_poly_coef),
        .i_raddr (rd_addr),
        .o_rdata (coef_q)
    );

    // Region decision on |angle|
    assign ae  = {1'b0, r_a};
    assign x0e = 26'(r_x0);
    assign x1e = 26'(r_x1);
    assign xae = 26'(r_xa);
    always_comb begin
        if (ae > x1e && ae < xae) begin
            region_w = acm_pkg::REGION_POLY;
        end else if (ae >= x0e && ae <= x1e) begin
            region_w = acm_pkg::REGION_LOW;
        end else if (ae >= xae) begin
            region_w = acm_pkg::REGION_HIGH;
        end else begin
            region_w = acm_pkg::REGION_NONE;
        end
    end

    // Segment operands
    assign sx0   = r_seg_hi ? r_xa : r_x0;
    assign sx1   = r_seg_hi ? r_xb : r_x1;
    assign sy0   = r_seg_hi ? r_ya : r_y0;
    assign sy1   = r_seg_hi ? r_yb : r_y1;
    assign den   = 26'(sx1) - 26'(sx0);
    assign dx    = ae - 26'(sx0);
    assign dy    = 33'(sy1) - 33'(sy0);
    assign dymag = dy[32] ? 33'(-dy) : 33'(dy);

    // Shared multiplier
    assign hmag = r_hacc[47] ? 48'(-r_hacc) : 48'(r_hacc);
    assign cmag = r_c[31] ? 32'(-r_c) : 32'(r_c);
    assign u    = {r_a, 9'd0};

    always_comb begin
        case (i_cmd.mul)
            acm_pkg::MUL_SQ:  begin mul_a = 33'(r_spd);         mul_b = 34'(r_spd);         end
            acm_pkg::MUL_GLO: begin mul_a = 33'(r_gain);        mul_b = 34'(r_sq[23:0]);    end
            acm_pkg::MUL_GHI: begin mul_a = 33'(r_gain);        mul_b = 34'(r_sq[47:24]);   end
            acm_pkg::MUL_HLO: begin mul_a = 33'(hmag[31:0]);    mul_b = u;                  end
            acm_pkg::MUL_HHI: begin mul_a = 33'(hmag[47:32]);   mul_b = u;                  end
            acm_pkg::MUL_SEG: begin mul_a = dymag;              mul_b = 34'(dx[25:0]);      end
            acm_pkg::MUL_FLO: begin mul_a = 33'(cmag);          mul_b = 34'(r_g[31:0]);     end
            acm_pkg::MUL_FHI: begin mul_a = 33'(cmag);          mul_b = 34'(r_g[39:32]);    end
            default:          begin mul_a = '0;                 mul_b = '0;                 end
        endcase
    end

    // Rounding and step results
    assign hrnd = r_wide + (82'(1) << 31);
    assign ht   = hrnd[81:32];
    assign hcap = (ht > (50'(1) << 48)) ? (49'(1) << 48) : ht[48:0];
    assign hsgn = r_hacc[47] ? -$signed(51'(hcap)) : $signed(51'(hcap));
    assign hsum = 52'(hsgn) + 52'(r_hcoef);
    assign pm   = 40'((hmag + 48'd128) >> 8);

    assign dvd = r_wide[58:0] + 59'(den[24:1]);
    always_comb begin
        d_rem = r_rem;
        d_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            d_rem = {d_rem[24:0], d_quo[33]};
            d_quo = {d_quo[32:0], 1'b0};
            if (d_rem >= 26'(den[24:0])) begin
                d_rem    = d_rem - 26'(den[24:0]);
                d_quo[0] = 1'b1;
            end
        end
    end
    assign q35  = r_dovf ? (35'(1) << 34) : {1'b0, r_quo};
    assign cmir = (r_odd && r_slip[24]) ? -r_cpre : r_cpre;

    assign frnd = r_wide + (82'(1) << 23);
    assign ft   = frnd[81:24];
    assign fcap = (ft > (58'(1) << 48)) ? (49'(1) << 48) : ft[48:0];
    assign fs   = r_c[31] ? -$signed(50'(fcap)) : $signed(50'(fcap));
    assign fd   = r_dir ? fs : -fs;

    // Multiplier product and wide accumulator
    always_ff @(posedge i_clk) begin
        r_mul <= mul_a * mul_b;
        case (i_cmd.acc)
            acm_pkg::ACC_LOAD:  r_wide <= 82'(r_mul);
            acm_pkg::ACC_ADD24: r_wide <= r_wide + (82'(r_mul) << 24);
            acm_pkg::ACC_ADD32: r_wide <= r_wide + (82'(r_mul) << 32);
            acm_pkg::ACC_SQ:    r_sq   <= r_mul[47:0];
            default: ;
        endcase
    end

    // Capture table reads
    always_ff @(posedge i_clk) begin
        case (i_cmd.cap)
            acm_pkg::CAP_P0: begin r_x0 <= ang_q; r_y0 <= val_q; end
            acm_pkg::CAP_P1: begin r_x1 <= ang_q; r_y1 <= val_q; end
            acm_pkg::CAP_PA: begin r_xa <= ang_q; r_ya <= val_q; end
            acm_pkg::CAP_PB: begin r_xb <= ang_q; r_yb <= val_q; end
            acm_pkg::CAP_COEF: r_hcoef <= coef_q;
            default: ;
        endcase
    end

    // Step operations
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            acm_pkg::OP_LOAD: begin
                r_coef_o   <= '0;
                r_force_o  <= '0;
                r_region_o <= acm_pkg::REGION_NONE;
            end
            acm_pkg::OP_LATCH: begin
                r_slip <= i_slip_angle;
                r_a    <= i_slip_angle[24] ? 25'(-i_slip_angle) : 25'(i_slip_angle);
                r_spd  <= i_speed;
            end
            acm_pkg::OP_DECIDE: begin
                r_g      <= hrnd[71:32];
                r_region <= region_w;
                r_seg_hi <= (region_w == acm_pkg::REGION_HIGH);
                // top coefficient seeds the Horner accumulator
                r_hacc   <= coef_q;
                r_idx    <= idx_nm2;
                if (region_w == acm_pkg::REGION_NONE) begin
                    r_coef_o   <= '0;
                    r_force_o  <= '0;
                    r_region_o <= acm_pkg::REGION_NONE;
                end
            end
            acm_pkg::OP_HSTEP: begin
                r_hacc <= sat48(hsum);
                r_idx  <= r_idx - AW'(1);
            end
            acm_pkg::OP_PEND: r_cpre <= r_hacc[47] ? -42'(pm) : 42'(pm);
            acm_pkg::OP_FLAT: r_cpre <= 42'(sy0);
            acm_pkg::OP_DIVINIT: begin
                r_dovf <= (dvd[58:34] >= den[24:0]);
                r_rem  <= 26'(dvd[58:34]);
                r_quo  <= dvd[33:0];
                r_dcnt <= '0;
            end
            acm_pkg::OP_DIV: begin
                r_rem  <= d_rem;
                r_quo  <= d_quo;
                r_dcnt <= r_dcnt + 5'd1;
            end
            acm_pkg::OP_SEND: r_cpre <= dy[32] ? 42'(sy0) - 42'(q35) : 42'(sy0) + 42'(q35);
            acm_pkg::OP_CSAT: r_c <= sat32(cmir);
            acm_pkg::OP_FEND: begin
                r_coef_o   <= r_c;
                r_force_o  <= sat48(52'(fd));
                r_region_o <= r_region;
            end
            default: ;
        endcase
    end

    assign o_stat.region   = region_w;
    assign o_stat.den_le0  = den[25] || (den == 26'sd0);
    assign o_stat.div_last = (r_dcnt == 5'd16);
    assign o_stat.idx_zero = (r_idx == '0);

    assign o_coefficient = r_coef_o;
    assign o_force_res   = r_force_o;
    assign o_region      = r_region_o;

endmodule

`default_nettype wire

/* rtl/core/acm_ctrl.sv */
`default_nettype none

module acm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic           i_kind,
    output logic                o_stall,
    output logic                o_valid,
    input  wire logic           i_stall,
    input  wire acm_pkg::t_stat i_stat,
    output acm_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_G0, S_G1, S_G2, S_G3, S_G4, S_G5,
        S_H0, S_H1, S_H2, S_H3, S_PEND,
        S_S0, S_S1, S_S2, S_S3, S_S4,
        S_F0, S_F1, S_F2, S_F3, S_F4,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '{op: acm_pkg::OP_NONE, rd: acm_pkg::RD_ZERO, cap: acm_pkg::CAP_NONE,
                    mul: acm_pkg::MUL_NONE, acc: acm_pkg::ACC_NONE};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind) begin
                        o_cmd.op = acm_pkg::OP_LATCH;
                        n_state  = S_G0;
                    end else begin
                        o_cmd.op = acm_pkg::OP_LOAD;
                        n_state  = S_OUT;
                    end
                end
            end
            S_G0: begin
                o_cmd.rd  = acm_pkg::RD_ZERO;
                o_cmd.mul = acm_pkg::MUL_SQ;
                n_state   = S_G1;
            end
            S_G1: begin
                o_cmd.rd  = acm_pkg::RD_ONE;
                o_cmd.cap = acm_pkg::CAP_P0;
                o_cmd.acc = acm_pkg::ACC_SQ;
                n_state   = S_G2;
            end
            S_G2: begin
                o_cmd.rd  = acm_pkg::RD_NM2;
                o_cmd.cap = acm_pkg::CAP_P1;
                o_cmd.mul = acm_pkg::MUL_GLO;
                n_state   = S_G3;
            end
            S_G3: begin
                o_cmd.rd  = acm_pkg::RD_NM1;
                o_cmd.cap = acm_pkg::CAP_PA;
                o_cmd.mul = acm_pkg::MUL_GHI;
                o_cmd.acc = acm_pkg::ACC_LOAD;
                n_state   = S_G4;
            end
            S_G4: begin
                o_cmd.rd  = acm_pkg::RD_NM1;
                o_cmd.cap = acm_pkg::CAP_PB;
                o_cmd.acc = acm_pkg::ACC_ADD24;
                n_state   = S_G5;
            end
            S_G5: begin
                // read data still holds the top coefficient
                o_cmd.rd = acm_pkg::RD_NM1;
                o_cmd.op = acm_pkg::OP_DECIDE;
                case (i_stat.region)
                    acm_pkg::REGION_POLY: n_state = S_H0;
                    acm_pkg::REGION_LOW:  n_state = S_S0;
                    acm_pkg::REGION_HIGH: n_state = S_S0;
                    default:              n_state = S_OUT;
                endcase
            end
            S_H0: begin
                o_cmd.rd  = acm_pkg::RD_IDX;
                o_cmd.mul = acm_pkg::MUL_HLO;
                n_state   = S_H1;
            end
            S_H1: begin
                o_cmd.rd  = acm_pkg::RD_IDX;
                o_cmd.cap = acm_pkg::CAP_COEF;
                o_cmd.mul = acm_pkg::MUL_HHI;
                o_cmd.acc = acm_pkg::ACC_LOAD;
                n_state   = S_H2;
            end
            S_H2: begin
                o_cmd.acc = acm_pkg::ACC_ADD32;
                n_state   = S_H3;
            end
            S_H3: begin
                o_cmd.op = acm_pkg::OP_HSTEP;
                n_state  = i_stat.idx_zero ? S_PEND : S_H0;
            end
            S_PEND: begin
                o_cmd.op = acm_pkg::OP_PEND;
                n_state  = S_F0;
            end
            S_S0: begin
                if (i_stat.den_le0) begin
                    o_cmd.op = acm_pkg::OP_FLAT;
                    n_state  = S_F0;
                end else begin
                    o_cmd.mul = acm_pkg::MUL_SEG;
                    n_state   = S_S1;
                end
            end
            S_S1: begin
                o_cmd.acc = acm_pkg::ACC_LOAD;
                n_state   = S_S2;
            end
            S_S2: begin
                o_cmd.op = acm_pkg::OP_DIVINIT;
                n_state  = S_S3;
            end
            S_S3: begin
                o_cmd.op = acm_pkg::OP_DIV;
                if (i_stat.div_last) begin
                    n_state = S_S4;
                end
            end
            S_S4: begin
                o_cmd.op = acm_pkg::OP_SEND;
                n_state  = S_F0;
            end
            S_F0: begin
                o_cmd.op = acm_pkg::OP_CSAT;
                n_state  = S_F1;
            end
            S_F1: begin
                o_cmd.mul = acm_pkg::MUL_FLO;
                n_state   = S_F2;
            end
            S_F2: begin
                o_cmd.mul = acm_pkg::MUL_FHI;
                o_cmd.acc = acm_pkg::ACC_LOAD;
                n_state   = S_F3;
            end
            S_F3: begin
                o_cmd.acc = acm_pkg::ACC_ADD32;
                n_state   = S_F4;
            end
            S_F4: begin
                o_cmd.op = acm_pkg::OP_FEND;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (n_state == S_OUT);
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/core/aero_coefficient_map_eval_unit.sv */
`default_nettype none

// Aerodynamic coefficient map evaluator. Load items write one entry of the
// angle, value and polynomial coefficient tables and return a zero result
// with region 3. Evaluate items take a slip angle and a speed and return the
// map coefficient (Horner polynomial, or linear end segments) and the force
// scaled by the pressure gain and speed squared. One item is worked on at a
// time; all products go through a single shared 33x34 multiplier whose
// wide products are built from two partial products. In the polynomial
// region an evaluate runs one Horner step per point below the top one; a
// linear segment uses a two-bit-per-cycle divider, a flat or descending
// segment skips it, and the result waits while the receiver stalls.
// Configuration must be written only while no item is in flight; the block
// itself does not enforce this.
module aero_coefficient_map_eval_unit #(
    parameter int MAX_POINTS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic [3:0]         i_entry_index,
    input  wire logic signed [24:0] i_point_angle,
    input  wire logic signed [31:0] i_point_value,
    input  wire logic signed [47:0] i_poly_coef,
    input  wire logic signed [24:0] i_slip_angle,
    input  wire logic [23:0]        i_speed,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_coefficient,
    output logic signed [47:0]      o_force_res,
    output logic [1:0]              o_region
);

    acm_pkg::t_cmd  cmd;
    acm_pkg::t_stat stat;

    // Sequence the evaluation
    acm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Tables, arithmetic and result registers
    acm_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_entry_index (i_entry_index),
        .i_point_angle (i_point_angle),
        .i_point_value (i_point_value),
        .i_poly_coef   (i_poly_coef),
        .i_slip_angle  (i_slip_angle),
        .i_speed       (i_speed),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_coefficient (o_coefficient),
        .o_force_res   (o_force_res),
        .o_region      (o_region)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int  N_PHASES      = 12;
    localparam int  ITEMS_PER_PH  = 150;
    localparam int  SETTLE_CYCLES = 120;
    localparam int  CYCLE_LIMIT   = 1500000;
    localparam int  TAB_DEPTH     = 16;

    typedef struct {
        logic               kind;
        logic [3:0]         idx;
        logic signed [24:0] ang;
        logic signed [31:0] val;
        logic signed [47:0] pcoef;
        logic signed [24:0] slip;
        logic [23:0]        speed;
    } t_map_item;

    typedef struct {
        logic signed [31:0] coef;
        logic signed [47:0] frc;
        acm_pkg::t_region   region;
    } t_map_result;

    typedef struct {
        t_map_item   it;
        bit          typed;
        t_map_result want;
    } t_dir_row;

    // DUT connections; the inputs are known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = acm_pkg::CFG_POINT_COUNT;
    logic [23:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_kind = 1'b0;
    logic [3:0]         i_entry_index = '0;
    logic signed [24:0] i_point_angle = '0;
    logic signed [31:0] i_point_value = '0;
    logic signed [47:0] i_poly_coef = '0;
    logic signed [24:0] i_slip_angle = '0;
    logic [23:0]        i_speed = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_coefficient;
    logic signed [47:0] o_force_res;
    logic [1:0]         o_region;

    aero_coefficient_map_eval_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_point_angle (i_point_angle),
        .i_point_value (i_point_value),
        .i_poly_coef   (i_poly_coef),
        .i_slip_angle  (i_slip_angle),
        .i_speed       (i_speed),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_coefficient (o_coefficient),
        .o_force_res   (o_force_res),
        .o_region      (o_region)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the map tables and registers
    longint          map_ang [TAB_DEPTH];
    longint          map_val [TAB_DEPTH];
    longint          map_coef[TAB_DEPTH];
    logic [4:0]      sh_points = 5'd16;
    logic            sh_odd = 1'b0;
    logic            sh_dir_pos = 1'b1;
    logic [23:0]     sh_gain = '0;

    t_map_result     pending_q[$];
    int              idle_mode = 0;
    int              mismatches = 0;
    int              cycles = 0;
    int              n_loads = 0;
    int              region_seen[4] = '{0, 0, 0, 0};
    int              phase_count = 0;

    // round(a*b >> sh), half up, capped
    function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b,
                                                  int sh, longint unsigned cap);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << (sh - 1));
        p = p >> sh;
        if (p > 128'(cap))
            return cap;
        return p[63:0];
    endfunction

    // Signed magnitude version, rounding half away from zero
    function automatic longint smul_round(longint a, longint unsigned b, int sh,
                                          longint unsigned cap);
        longint unsigned mag;
        longint          r;
        mag = (a < 0) ? longint'(-a) : a;
        r = longint'(mul_round(mag, b, sh, cap));
        return (a < 0) ? -r : r;
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v >= lim)
            return lim - 1;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Linear interpolation over one segment of the map
    function automatic longint seg_interp(int i0, int i1, longint a);
        longint          den, num;
        longint unsigned mag, q;
        den = map_ang[i1] - map_ang[i0];
        if (den <= 0)
            return map_val[i0];
        num = (map_val[i1] - map_val[i0]) * (a - map_ang[i0]);
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag + longint'(den) / 2) / longint'(den);
        return (num < 0) ? map_val[i0] - longint'(q) : map_val[i0] + longint'(q);
    endfunction

    // Expected result of one item; loads update the shadow tables
    function automatic t_map_result predict_map(t_map_item it);
        t_map_result     r;
        int              n;
        longint          slip, a, c, acc, frc;
        longint unsigned u, g, spd;
        r.coef = '0;
        r.frc = '0;
        r.region = acm_pkg::REGION_NONE;
        if (!it.kind) begin
            map_ang[it.idx] = longint'(it.ang);
            map_val[it.idx] = longint'(it.val);
            map_coef[it.idx] = longint'(it.pcoef);
            return r;
        end
        n = (sh_points < 4) ? 4 : (sh_points > TAB_DEPTH) ? TAB_DEPTH : sh_points;
        slip = longint'(it.slip);
        a = (slip < 0) ? -slip : slip;
        if (a > map_ang[1] && a < map_ang[n-2]) begin
            u = a << 9;
            acc = map_coef[n-1];
            for (int i = n - 2; i >= 0; i--)
                acc = clip(smul_round(acc, u, 32, 64'd1 << 48) + map_coef[i], 64'sd1 << 47);
            c = smul_round(acc, 1, 8, 64'd1 << 48);
            r.region = acm_pkg::REGION_POLY;
        end else if (a >= map_ang[0] && a <= map_ang[1]) begin
            c = seg_interp(0, 1, a);
            r.region = acm_pkg::REGION_LOW;
        end else if (a >= map_ang[n-2]) begin
            c = seg_interp(n - 2, n - 1, a);
            r.region = acm_pkg::REGION_HIGH;
        end else begin
            return r;
        end
        if (sh_odd && slip < 0)
            c = -c;
        c = clip(c, 64'sd1 << 31);
        spd = 64'(it.speed);
        g = mul_round(64'(sh_gain), spd * spd, 32, 64'd1 << 62);
        frc = smul_round(c, g, 24, 64'd1 << 48);
        if (!sh_dir_pos)
            frc = -frc;
        frc = clip(frc, 64'sd1 << 47);
        r.coef = c[31:0];
        r.frc = frc[47:0];
        return r;
    endfunction

    // Write one register and mirror it
    task automatic cfg_write(logic [1:0] idx, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            acm_pkg::CFG_POINT_COUNT: sh_points = data[4:0];
            acm_pkg::CFG_ODD_SYM:     sh_odd = data[0];
            acm_pkg::CFG_DIR_POS:     sh_dir_pos = data[0];
            acm_pkg::CFG_GAIN:        sh_gain = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drop valid and wait until the block has drained
    task automatic drain_all();
        i_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hand one item over and wait for it to be taken
    task automatic send_item(t_map_item it);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 13 : (idle_mode == 1) ? 63 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= it.kind;
        i_entry_index <= it.idx;
        i_point_angle <= it.ang;
        i_point_value <= it.val;
        i_poly_coef <= it.pcoef;
        i_slip_angle <= it.slip;
        i_speed <= it.speed;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (!it.kind)
            n_loads++;
    endtask

    task automatic send_predicted(t_map_item it);
        send_item(it);
        pending_q = {pending_q, predict_map(it)};
    endtask

    function automatic t_map_item blank_item();
        t_map_item it;
        it.kind = 1'b1;
        it.idx = '0;
        it.ang = '0;
        it.val = '0;
        it.pcoef = '0;
        it.slip = '0;
        it.speed = '0;
        return it;
    endfunction

    function automatic t_map_item load_item(int k, int ang, int val, longint pc);
        t_map_item it;
        it = blank_item();
        it.kind = 1'b0;
        it.idx = k[3:0];
        it.ang = 25'(ang);
        it.val = val;
        it.pcoef = pc[47:0];
        return it;
    endfunction

    function automatic t_map_item eval_item(int slip, int spd);
        t_map_item it;
        it = blank_item();
        it.slip = 25'(slip);
        it.speed = spd[23:0];
        return it;
    endfunction

    function automatic int rand_signed(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Fill the whole table with an ascending, well-formed map
    task automatic load_ordered_map();
        int     x;
        longint pc;
        x = $urandom_range(0, 4 << 16);
        for (int k = 0; k < TAB_DEPTH; k++) begin
            pc = longint'($signed({$urandom, $urandom})) >>> $urandom_range(16, 44);
            send_predicted(load_item(k, x, rand_signed(1 << 27), pc));
            x += $urandom_range(1 << 16, 11 << 16);
        end
    endtask

    // One random item: mostly evaluates, some loads that may break ordering
    function automatic t_map_item random_item();
        int        r;
        t_map_item it;
        r = $urandom_range(99);
        if (r < 12) begin
            it = load_item($urandom_range(15),
                           (r < 3) ? ((r & 1) ? 11796480 : -11796480) : rand_signed(11796480),
                           $urandom, longint'({$urandom, $urandom}));
        end else begin
            it = eval_item(($urandom_range(1)) ? rand_signed(11796480)
                                               : rand_signed(200 << 16),
                           ($urandom_range(7) == 0) ? 24'hFFFFFF : $urandom);
        end
        return it;
    endfunction

    // Result checker and receiver stall
    always @(posedge i_clk) begin : result_check
        t_map_result want;
        int          stall_pct;
        stall_pct = (idle_mode == 0) ? 63 : (idle_mode == 1) ? 13 : 0;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: coef=%0d force=%0d region=%0d",
                             o_coefficient, o_force_res, o_region);
            end else begin
                want = pending_q.pop_front();
                region_seen[want.region]++;
                if (o_coefficient !== want.coef || o_force_res !== want.frc
                        || o_region !== want.region) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: coef %0d/%0d force %0d/%0d region %0d/%0d",
                                 want.coef, o_coefficient, want.frc, o_force_res,
                                 want.region, o_region);
                end
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Directed table: ordered map, then the edges of each region
    t_dir_row dir_rows[$];

    int row_slip_list[8] = '{2 << 16, 5 << 16, 20 << 16, -(20 << 16), 44 << 16,
                             11796480, -11796480, 30 << 16};
    int row_speed_list[8] = '{1 << 16, 24'hFFFFFF, 3 << 16, 3 << 16, 0,
                              24'hFFFFFF, 24'hFFFFFF, 24'h800000};

    task automatic build_directed();
        t_dir_row    row;
        t_map_result zero;
        zero.coef = '0;
        zero.frc = '0;
        zero.region = acm_pkg::REGION_NONE;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            row.it = load_item(k, (2 + 3 * k) << 16, int'(k * 32'h0010_0000 - 32'h0060_0000),
                               ((k % 2) ? -(64'sd1 << 26) : (64'sd1 << 28)) >>> k);
            row.typed = 1'b1;
            row.want = zero;
            dir_rows = {dir_rows, row};
        end
        // Below the first point: out of range
        row.it = eval_item(0, 24'hFFFFFF);
        row.typed = 1'b1;
        row.want = zero;
        dir_rows = {dir_rows, row};
        row.typed = 1'b0;
        // Low segment ends, polynomial both signs, high bound, angle extremes
        foreach (row_slip_list[i]) begin
            row.it = eval_item(row_slip_list[i], row_speed_list[i]);
            dir_rows = {dir_rows, row};
        end
    endtask

    initial begin : stimulus
        int pc_list[N_PHASES] = '{16, 4, 0, 31, 3, 8, 12, 16, 5, 16, 10, 15};
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        cfg_write(acm_pkg::CFG_GAIN, 24'hFFFFFF);
        cfg_write(acm_pkg::CFG_ODD_SYM, 24'd1);
        build_directed();
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].it);
            if (dir_rows[i].typed) begin
                void'(predict_map(dir_rows[i].it));
                pending_q = {pending_q, dir_rows[i].want};
            end else begin
                pending_q = {pending_q, predict_map(dir_rows[i].it)};
            end
        end
        drain_all();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            idle_mode = ph / 4;
            phase_count++;
            cfg_write(acm_pkg::CFG_POINT_COUNT, 24'(pc_list[ph]));
            cfg_write(acm_pkg::CFG_ODD_SYM,
                      24'((ph == 0) ? 1 : (ph == 1) ? 0 : $urandom_range(1)));
            cfg_write(acm_pkg::CFG_DIR_POS,
                      24'((ph == 0) ? 0 : (ph == 1) ? 1 : $urandom_range(1)));
            cfg_write(acm_pkg::CFG_GAIN,
                      24'((ph == 0) ? 32'hFFFFFF : (ph == 1) ? 32'd0 : $urandom));
            load_ordered_map();
            for (int k = 0; k < ITEMS_PER_PH; k++) begin
                // Hold off until the block is empty, once
                if (ph == 2 && k == 75)
                    drain_all();
                send_predicted(random_item());
            end
            drain_all();
        end

        $display("covered %0d phases, %0d loads; regions poly/low/high/none: %0d/%0d/%0d/%0d",
                 phase_count, n_loads, region_seen[acm_pkg::REGION_POLY],
                 region_seen[acm_pkg::REGION_LOW], region_seen[acm_pkg::REGION_HIGH],
                 region_seen[acm_pkg::REGION_NONE]);
        $display("mismatches: %0d, results left over: %0d", mismatches, pending_q.size());
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/acm_pkg.sv
rtl/core/acm_ram.sv
rtl/core/acm_dp.sv
rtl/core/acm_ctrl.sv
rtl/core/aero_coefficient_map_eval_unit.sv
tb/sv/tb_top.sv
